>>> sv/sfadler_pkg.sv
// Shared types and constants for the sample-format Adler checksum block.
package sfadler_pkg;

    // Adler modulus and the helpers used by the running-sum update
    localparam logic [16:0] MOD_ADLER  = 17'd65521;
    localparam logic [17:0] MOD_ADLER2 = 18'd131042;
    // 2^32 mod 65521 is 225; dropping a 2^32 wrap is the same as adding 65521 - 225
    localparam logic [17:0] WRAP_ADJ   = 18'd65296;

    // sample_format codes
    localparam logic [2:0] FMT_U8  = 3'd0;
    localparam logic [2:0] FMT_S16 = 3'd1;
    localparam logic [2:0] FMT_S32 = 3'd2;
    localparam logic [2:0] FMT_FLT = 3'd3;
    localparam logic [2:0] FMT_DBL = 3'd4;

    // Exponent handling: kk is the power of two of the mantissa lsb after the 2^31 scale
    localparam logic [12:0] FLT_KK_SUB  = -13'sd118;
    localparam logic [12:0] FLT_KK_BIAS = 13'sd119;
    localparam logic [12:0] DBL_KK_SUB  = -13'sd1043;
    localparam logic [12:0] DBL_KK_BIAS = 13'sd1044;
    // At or above these biased exponents the scaled magnitude is 2^34 or more
    localparam logic [7:0]  FLT_E_SAT   = 8'd130;
    localparam logic [10:0] DBL_E_SAT   = 11'd1026;

    // Fixed point: 54 fraction bits, alignment shifter carries 64 extra low bits
    localparam logic [12:0] ALIGN_OFS   = 13'sd118;
    localparam logic [88:0] Z_HALF      = {3'b000, 1'b1, 85'b0};   // 2^31
    localparam logic [6:0]  JL_OFS_DBL  = 7'd1;
    localparam logic [6:0]  JL_OFS_FLT  = 7'd30;

    typedef struct packed {
        logic first;
        logic last;
        logic ok;
    } beat_ctl_t;

    typedef struct packed {
        beat_ctl_t   ctl;
        logic [15:0] vmod;   // mapped value mod 65521
        logic        vtop;   // mapped value bits 31..16 all ones
        logic [15:0] vlo;    // mapped value bits 15..0
    } mapped_t;

endpackage

>>> sv/sfadler_map.sv
// Sample mapping pipeline: format decode, float alignment and rounding, mod 65521 fold.
module sfadler_map (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [2:0]           sample_format,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [63:0]          in_sample,
    input  logic                 in_first,
    input  logic                 in_last,
    output logic                 out_valid,
    input  logic                 out_ready,
    output sfadler_pkg::mapped_t out_beat
);

    typedef struct packed {
        logic [63:0] smp;
        logic        first;
        logic        last;
    } st1_t;

    typedef struct packed {
        sfadler_pkg::beat_ctl_t ctl;
        logic                   direct;
        logic [31:0]            dv;
        logic                   neg;
        logic                   dbl;
        logic [52:0]            m;
        logic [12:0]            kk;
    } st2_t;

    typedef struct packed {
        sfadler_pkg::beat_ctl_t ctl;
        logic                   direct;
        logic [31:0]            dv;
        logic                   neg;
        logic                   dbl;
        logic [87:0]            yfix;
        logic                   yst;
    } st3_t;

    typedef struct packed {
        sfadler_pkg::beat_ctl_t ctl;
        logic                   direct;
        logic [31:0]            dv;
        logic                   dbl;
        logic [88:0]            z;
        logic                   zst;
    } st4_t;

    typedef struct packed {
        sfadler_pkg::beat_ctl_t ctl;
        logic                   direct;
        logic [31:0]            dv;
        logic [88:0]            z;
        logic                   zst;
        logic [6:0]             jl;
    } st5_t;

    typedef struct packed {
        sfadler_pkg::beat_ctl_t ctl;
        logic                   direct;
        logic [31:0]            dv;
        logic [88:0]            trunc;
        logic                   inc;
        logic [6:0]             jl;
    } st6_t;

    typedef struct packed {
        sfadler_pkg::beat_ctl_t ctl;
        logic [31:0]            v;
    } st7_t;

    logic [8:1] vld_reg;
    logic [8:1] adv;

    st1_t                 r1_reg;
    st2_t                 r2_reg, r2_next;
    st3_t                 r3_reg, r3_next;
    st4_t                 r4_reg, r4_next;
    st5_t                 r5_reg, r5_next;
    st6_t                 r6_reg, r6_next;
    st7_t                 r7_reg, r7_next;
    sfadler_pkg::mapped_t r8_reg, r8_next;

    logic [7:0]   e8;
    logic [22:0]  f23;
    logic [10:0]  e11;
    logic [51:0]  f52;
    logic [12:0]  shl_full;
    logic [191:0] wide;
    logic [5:0]   tp1;
    logic [88:0]  low_mask;
    logic [88:0]  rest_mask;
    logic         g_bit;
    logic         lsb_bit;
    logic         rest_bit;
    logic [89:0]  rsum;
    logic [35:0]  ival;
    logic [19:0]  x1;
    logic [16:0]  x2;

    // elastic stall chain: a stage moves when it is empty or the next one moves
    always_comb begin
        adv[8] = !vld_reg[8] || out_ready;
        for (int i = 7; i >= 1; i--) begin
            adv[i] = !vld_reg[i] || adv[i + 1];
        end
    end

    assign in_ready  = adv[1];
    assign out_valid = vld_reg[8];
    assign out_beat  = r8_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (adv[1]) begin
                vld_reg[1] <= in_valid;
            end
            for (int i = 2; i <= 8; i++) begin
                if (adv[i]) begin
                    vld_reg[i] <= vld_reg[i - 1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            r1_reg.smp   <= in_sample;
            r1_reg.first <= in_first;
            r1_reg.last  <= in_last;
        end
        if (adv[2]) r2_reg <= r2_next;
        if (adv[3]) r3_reg <= r3_next;
        if (adv[4]) r4_reg <= r4_next;
        if (adv[5]) r5_reg <= r5_next;
        if (adv[6]) r6_reg <= r6_next;
        if (adv[7]) r7_reg <= r7_next;
        if (adv[8]) r8_reg <= r8_next;
    end

    // Decode: integer formats finish here, floats split into mantissa and exponent
    assign e8  = r1_reg.smp[30:23];
    assign f23 = r1_reg.smp[22:0];
    assign e11 = r1_reg.smp[62:52];
    assign f52 = r1_reg.smp[51:0];

    always_comb begin
        r2_next.ctl.first = r1_reg.first;
        r2_next.ctl.last  = r1_reg.last;
        r2_next.ctl.ok    = 1'b1;
        r2_next.direct    = 1'b1;
        r2_next.dv        = '0;
        r2_next.neg       = 1'b0;
        r2_next.dbl       = 1'b0;
        r2_next.m         = '0;
        r2_next.kk        = '0;
        unique case (sample_format)
            sfadler_pkg::FMT_U8: begin
                r2_next.dv = {24'b0, r1_reg.smp[7:0]};
            end
            sfadler_pkg::FMT_S16: begin
                r2_next.dv = {16'b0, ~r1_reg.smp[15], r1_reg.smp[14:0]};
            end
            sfadler_pkg::FMT_S32: begin
                r2_next.dv = {~r1_reg.smp[31], r1_reg.smp[30:0]};
            end
            sfadler_pkg::FMT_FLT: begin
                r2_next.neg    = r1_reg.smp[31];
                r2_next.direct = 1'b0;
                r2_next.m      = {29'b0, (e8 != 8'd0), f23};
                r2_next.kk     = (e8 == 8'd0) ? sfadler_pkg::FLT_KK_SUB
                                              : {5'b0, e8} - sfadler_pkg::FLT_KK_BIAS;
                if (e8 == 8'hFF) begin
                    r2_next.direct = 1'b1;
                    r2_next.dv     = (f23 != '0 || r1_reg.smp[31]) ? '0 : '1;
                end else if (e8 == 8'd0 && f23 == '0) begin
                    r2_next.direct = 1'b1;
                    r2_next.dv     = 32'h8000_0000;
                end else if (e8 >= sfadler_pkg::FLT_E_SAT) begin
                    r2_next.direct = 1'b1;
                    r2_next.dv     = r1_reg.smp[31] ? '0 : '1;
                end
            end
            sfadler_pkg::FMT_DBL: begin
                r2_next.neg    = r1_reg.smp[63];
                r2_next.dbl    = 1'b1;
                r2_next.direct = 1'b0;
                r2_next.m      = {(e11 != 11'd0), f52};
                r2_next.kk     = (e11 == 11'd0) ? sfadler_pkg::DBL_KK_SUB
                                                : {2'b0, e11} - sfadler_pkg::DBL_KK_BIAS;
                if (e11 == 11'h7FF) begin
                    r2_next.direct = 1'b1;
                    r2_next.dv     = (f52 != '0 || r1_reg.smp[63]) ? '0 : '1;
                end else if (e11 == 11'd0 && f52 == '0) begin
                    r2_next.direct = 1'b1;
                    r2_next.dv     = 32'h8000_0000;
                end else if (e11 >= sfadler_pkg::DBL_E_SAT) begin
                    r2_next.direct = 1'b1;
                    r2_next.dv     = r1_reg.smp[63] ? '0 : '1;
                end
            end
            default: begin
                r2_next.ctl.ok = 1'b0;
            end
        endcase
    end

    // Align |x| * 2^31 into 34.54 fixed point; bits shifted out go to sticky
    assign shl_full = r2_reg.kk + sfadler_pkg::ALIGN_OFS;
    assign wide     = 192'(r2_reg.m) << shl_full[7:0];

    always_comb begin
        r3_next.ctl    = r2_reg.ctl;
        r3_next.direct = r2_reg.direct;
        r3_next.dv     = r2_reg.dv;
        r3_next.neg    = r2_reg.neg;
        r3_next.dbl    = r2_reg.dbl;
        if (shl_full[12]) begin
            r3_next.yfix = '0;
            r3_next.yst  = 1'b1;
        end else begin
            r3_next.yfix = wide[151:64];
            r3_next.yst  = |wide[63:0];
        end
    end

    // z = 2^31 +/- |y|; a negative sample subtracts the sticky as one ulp
    always_comb begin
        r4_next.ctl    = r3_reg.ctl;
        r4_next.direct = r3_reg.direct;
        r4_next.dv     = r3_reg.dv;
        r4_next.dbl    = r3_reg.dbl;
        r4_next.zst    = r3_reg.yst;
        if (r3_reg.neg) begin
            r4_next.z = sfadler_pkg::Z_HALF - {1'b0, r3_reg.yfix} - 89'(r3_reg.yst);
        end else begin
            r4_next.z = sfadler_pkg::Z_HALF + {1'b0, r3_reg.yfix};
        end
        // magnitude of 2^31 or more below zero: nothing left
        if (!r3_reg.direct && r3_reg.neg && (|r3_reg.yfix[87:85])) begin
            r4_next.direct = 1'b1;
            r4_next.dv     = '0;
        end
    end

    // Leading one of the integer part sets the rounding position
    always_comb begin
        tp1 = '0;
        for (int i = 0; i < 35; i++) begin
            if (r4_reg.z[54 + i]) begin
                tp1 = 6'(i + 1);
            end
        end
        r5_next.ctl    = r4_reg.ctl;
        r5_next.direct = r4_reg.direct;
        r5_next.dv     = r4_reg.dv;
        r5_next.z      = r4_reg.z;
        r5_next.zst    = r4_reg.zst;
        r5_next.jl     = 7'(tp1) + (r4_reg.dbl ? sfadler_pkg::JL_OFS_DBL
                                               : sfadler_pkg::JL_OFS_FLT);
    end

    // Round to nearest even at bit jl
    assign low_mask  = (89'(1) << r5_reg.jl) - 89'(1);
    assign rest_mask = low_mask >> 1;
    assign g_bit     = r5_reg.z[r5_reg.jl - 7'd1];
    assign lsb_bit   = r5_reg.z[r5_reg.jl];
    assign rest_bit  = r5_reg.zst || (|(r5_reg.z & rest_mask));

    always_comb begin
        r6_next.ctl    = r5_reg.ctl;
        r6_next.direct = r5_reg.direct;
        r6_next.dv     = r5_reg.dv;
        r6_next.jl     = r5_reg.jl;
        r6_next.inc    = g_bit && (rest_bit || lsb_bit);
        r6_next.trunc  = r5_reg.z & ~low_mask;
    end

    assign rsum = {1'b0, r6_reg.trunc} + (r6_reg.inc ? (90'(1) << r6_reg.jl) : 90'(0));
    assign ival = rsum[89:54];

    always_comb begin
        r7_next.ctl = r6_reg.ctl;
        if (r6_reg.direct) begin
            r7_next.v = r6_reg.dv;
        end else if (|ival[35:32]) begin
            r7_next.v = '1;
        end else begin
            r7_next.v = ival[31:0];
        end
    end

    // v mod 65521 by folding with 2^16 = 15
    assign x1 = {r7_reg.v[31:16], 4'b0} - {4'b0, r7_reg.v[31:16]} + {4'b0, r7_reg.v[15:0]};
    assign x2 = {9'b0, x1[19:16], 4'b0} - {13'b0, x1[19:16]} + {1'b0, x1[15:0]};

    always_comb begin
        r8_next.ctl  = r7_reg.ctl;
        r8_next.vtop = &r7_reg.v[31:16];
        r8_next.vlo  = r7_reg.v[15:0];
        if (x2 >= sfadler_pkg::MOD_ADLER) begin
            r8_next.vmod = 16'(x2 - sfadler_pkg::MOD_ADLER);
        end else begin
            r8_next.vmod = x2[15:0];
        end
    end

`ifndef NO_ASSERTIONS
    a_vmod_range: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[8] |-> ({1'b0, r8_reg.vmod} < sfadler_pkg::MOD_ADLER))
        else $error("mapped residue out of range");

    a_jl_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[5] && !r5_reg.direct) |-> (r5_reg.jl >= 7'd1 && r5_reg.jl <= 7'd65))
        else $error("rounding position out of range");

    a_full_when_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_ready |-> (&vld_reg && !out_ready))
        else $error("input stalled with a free stage");
`endif

endmodule

>>> sv/sample_format_adler_checksum_top.sv
// Adler-style checksum over a plane of audio samples in u8, s16, s32, float or double.
//
// Input beats on s_t*: s_tdata carries one raw sample, s_tuser marks the first
// sample of a plane (sums restart from zero) and s_tlast the last one. For the
// last sample of a plane one beat leaves on m_t*: m_tdata = {sum_b, sum_a}.
// Other samples produce no output beat.
// cfg_we/cfg_wdata write the sample format (0 u8, 1 s16, 2 s32, 3 float,
// 4 double; other codes add nothing to the sums); write it only while idle.
// Throughput is one sample per cycle while no plane end waits on a stalled
// receiver: an eight-stage mapping pipeline (decode, float alignment, offset,
// leading-one search, rounding, saturation, mod fold) feeds a running-sum
// update, which is the only loop in the design.
// Reset empties the pipeline, clears both sums and the output valid flag and
// sets the format to u8.
// While the receiver stalls, the checksum waits in the output register and
// samples keep entering until the next plane end reaches the sum stage; from
// then s_tready falls only once all pipeline stages are full.
module sample_format_adler_checksum_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_wdata,   // sample_format
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,     // [63:0] sample_bits
    input  logic        s_tuser,     // first_of_plane
    input  logic        s_tlast,     // last_of_plane
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata      // [31:0] checksum
);

    logic [2:0]           sample_format_reg;
    logic [15:0]          sum_a_reg, sum_a_next;
    logic [15:0]          sum_b_reg, sum_b_next;
    logic                 m_tvalid_reg;
    logic [31:0]          m_tdata_reg;

    logic                 map_valid;
    logic                 map_ready;
    sfadler_pkg::mapped_t map_beat;
    logic                 take;
    logic [15:0]          a_base;
    logic [15:0]          b_base;
    logic [16:0]          lo_sum;
    logic                 wrap;
    logic [17:0]          xa;
    logic [15:0]          a_red;
    logic [16:0]          xb;

    sfadler_map u_map (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .sample_format (sample_format_reg),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_sample     (s_tdata),
        .in_first      (s_tuser),
        .in_last       (s_tlast),
        .out_valid     (map_valid),
        .out_ready     (map_ready),
        .out_beat      (map_beat)
    );

    // a beat with no result never waits on the output register
    assign map_ready = !map_beat.ctl.last || !m_tvalid_reg || m_tready;
    assign take      = map_valid && map_ready;

    assign a_base = map_beat.ctl.first ? '0 : sum_a_reg;
    assign b_base = map_beat.ctl.first ? '0 : sum_b_reg;

    // a + v overflows 32 bits only when v[31:16] is all ones
    assign lo_sum = {1'b0, a_base} + {1'b0, map_beat.vlo};
    assign wrap   = map_beat.vtop && lo_sum[16];
    assign xa     = {2'b0, a_base} + {2'b0, map_beat.vmod}
                  + (wrap ? sfadler_pkg::WRAP_ADJ : 18'd0);

    always_comb begin
        priority if (xa >= sfadler_pkg::MOD_ADLER2) begin
            a_red = 16'(xa - sfadler_pkg::MOD_ADLER2);
        end else if (xa >= {1'b0, sfadler_pkg::MOD_ADLER}) begin
            a_red = 16'(xa - {1'b0, sfadler_pkg::MOD_ADLER});
        end else begin
            a_red = xa[15:0];
        end
    end

    assign sum_a_next = map_beat.ctl.ok ? a_red : a_base;
    assign xb         = {1'b0, b_base} + {1'b0, sum_a_next};

    always_comb begin
        if (!map_beat.ctl.ok) begin
            sum_b_next = b_base;
        end else if (xb >= sfadler_pkg::MOD_ADLER) begin
            sum_b_next = 16'(xb - sfadler_pkg::MOD_ADLER);
        end else begin
            sum_b_next = xb[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_format_reg <= sfadler_pkg::FMT_U8;
            sum_a_reg         <= '0;
            sum_b_reg         <= '0;
            m_tvalid_reg      <= 1'b0;
        end else begin
            if (cfg_we) begin
                sample_format_reg <= cfg_wdata;
            end
            if (take) begin
                sum_a_reg <= sum_a_next;
                sum_b_reg <= sum_b_next;
            end
            if (take && map_beat.ctl.last) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take && map_beat.ctl.last) begin
            m_tdata_reg <= {sum_b_next, sum_a_next};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef NO_ASSERTIONS
    a_sums_reduced: assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, sum_a_reg} < sfadler_pkg::MOD_ADLER)
        && ({1'b0, sum_b_reg} < sfadler_pkg::MOD_ADLER))
        else $error("running sum not reduced");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid_reg && !m_tready))
        else $error("input stalled without a waiting checksum");

    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && map_beat.ctl.last) |=>
            (m_tvalid_reg && m_tdata_reg == $past({sum_b_next, sum_a_next})))
        else $error("checksum not presented after plane end");
`endif

endmodule

>>> test/sample_format_adler_checksum_top_tb.sv
// Self-checking testbench for the sample-format Adler checksum block, with a bit-exact predictor.
`timescale 1ns / 100ps

module sample_format_adler_checksum_top_tb;

    // format codes the block leaves without a mapping
    localparam logic [2:0] FMT_RSVD5 = 3'd5;
    localparam logic [2:0] FMT_RSVD6 = 3'd6;
    localparam logic [2:0] FMT_RSVD7 = 3'd7;

    localparam logic [31:0] ALL_ONES     = 32'hFFFF_FFFF;
    localparam logic [31:0] ZERO_OFFSET  = 32'h8000_0000;
    localparam logic [99:0] FIX_HALF     = 100'd1 << 95;   // 2^31 with 64 fraction bits
    localparam int          SETTLE_CYCLES = 16;
    localparam int          CYCLE_LIMIT   = 400000;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [2:0]  cfg_wdata = 3'd0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata   = 64'd0;
    logic        s_tuser   = 1'b0;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;

    // predictor state
    logic [2:0]  sample_fmt = sfadler_pkg::FMT_U8;
    logic [15:0] run_a = 16'd0;
    logic [15:0] run_b = 16'd0;
    logic [31:0] checksum_q[$];

    int          src_idle_pct   = 0;
    int          sink_stall_pct = 0;
    int          err_count      = 0;
    int          cycle_count    = 0;
    logic [31:0] due_sum;

    sample_format_adler_checksum_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // IEEE single/double to offset-binary: trunc(round(x * 2^31 + 2^31)), saturating
    function automatic logic [31:0] float_to_offset(input logic [63:0] raw, input bit dbl);
        logic        neg;
        logic        stk;
        logic        g;
        logic        rest;
        logic        lsb;
        logic [63:0] m;
        logic [99:0] mag;
        logic [99:0] s;
        int          ex;
        int          k;
        int          prec;
        int          len;
        int          sh;
        int          top;
        int          idx;
        int          i;
        if (dbl) begin
            neg  = raw[63];
            ex   = int'(raw[62:52]);
            m    = {12'd0, raw[51:0]};
            prec = 53;
            if (ex == 2047)
                return (m != 0) ? 32'd0 : (neg ? 32'd0 : ALL_ONES);
            if (ex == 0) begin
                k = -1074;
            end else begin
                m[52] = 1'b1;
                k = ex - 1075;
            end
        end else begin
            neg  = raw[31];
            ex   = int'(raw[30:23]);
            m    = {41'd0, raw[22:0]};
            prec = 24;
            if (ex == 255)
                return (m != 0) ? 32'd0 : (neg ? 32'd0 : ALL_ONES);
            if (ex == 0) begin
                k = -149;
            end else begin
                m[23] = 1'b1;
                k = ex - 150;
            end
        end
        if (m == 0)
            return ZERO_OFFSET;
        k = k + 31;
        len = 0;
        for (i = 0; i < 64; i++)
            if (m[i]) len = i + 1;
        if (len + k >= 35)
            return neg ? 32'd0 : ALL_ONES;

        // |y| with 64 fraction bits, sticky for anything shifted out
        sh  = k + 64;
        stk = 1'b0;
        if (sh >= 0) begin
            mag = 100'(m) << sh;
        end else if (-sh >= 64) begin
            mag = '0;
            stk = 1'b1;
        end else begin
            mag = 100'(m >> (-sh));
            stk = (m & ((64'd1 << (-sh)) - 64'd1)) != 0;
        end

        if (!neg) begin
            s = mag + FIX_HALF;
        end else begin
            if (mag >= FIX_HALF)
                return 32'd0;
            s = FIX_HALF - mag - (stk ? 100'd1 : 100'd0);
        end

        // below one: only rounds up to one when within half an ulp of it
        if (s[99:64] == 0)
            return (s[63:0] >= ~((64'd1 << (63 - prec)) - 64'd1)) ? 32'd1 : 32'd0;

        top = 0;
        for (i = 0; i < 100; i++)
            if (s[i]) top = i;
        idx  = top - prec + 1;
        g    = s[idx - 1];
        rest = stk || ((s & ((100'd1 << (idx - 1)) - 100'd1)) != 0);
        lsb  = s[idx];
        s    = s & ~((100'd1 << idx) - 100'd1);
        if (g && (rest || lsb))
            s = s + (100'd1 << idx);
        if (s[99:96] != 0)
            return ALL_ONES;
        return s[95:64];
    endfunction

    // running-sum update for one accepted sample; queues the checksum at plane end
    task automatic fold_sample(input logic [63:0] bits, input logic first, input logic last);
        logic [31:0] v;
        logic [31:0] t;
        bit          mapped;
        mapped = 1'b1;
        v      = 32'd0;
        if (first) begin
            run_a = 16'd0;
            run_b = 16'd0;
        end
        case (sample_fmt)
            sfadler_pkg::FMT_U8:  v = {24'd0, bits[7:0]};
            sfadler_pkg::FMT_S16: v = {16'd0, bits[15:0] ^ 16'h8000};
            sfadler_pkg::FMT_S32: v = bits[31:0] ^ 32'h8000_0000;
            sfadler_pkg::FMT_FLT: v = float_to_offset(bits, 1'b0);
            sfadler_pkg::FMT_DBL: v = float_to_offset(bits, 1'b1);
            default: mapped = 1'b0;
        endcase
        if (mapped) begin
            t     = {16'd0, run_a} + v;
            run_a = 16'(t % sfadler_pkg::MOD_ADLER);
            run_b = 16'(({16'd0, run_b} + {16'd0, run_a}) % sfadler_pkg::MOD_ADLER);
        end
        if (last)
            checksum_q.push_back({run_b, run_a});
    endtask

    task automatic push_sample(input logic [63:0] bits, input logic first, input logic last);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= bits;
        s_tuser  <= first;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        fold_sample(bits, first, last);
    endtask

    // drain the block, then write the format register
    task automatic set_format(input logic [2:0] fmt);
        s_tvalid <= 1'b0;
        while (checksum_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= fmt;
        @(posedge aclk);
        cfg_we     <= 1'b0;
        sample_fmt = fmt;
    endtask

    function automatic logic [63:0] pick_float(input bit dbl);
        logic [63:0] mant;
        logic        sgn;
        int          bias;
        int          emax;
        int          ex;
        sgn  = 1'($urandom_range(1));
        mant = {$urandom, $urandom};
        if ($urandom_range(3) == 0)
            mant = mant & (64'hFFFF_FFFF_FFFF_FFFF << $urandom_range(50));
        bias = dbl ? 1023 : 127;
        emax = dbl ? 2047 : 255;
        case ($urandom_range(9))
            0: ex = $urandom_range(emax);
            1: begin
                ex = emax;
                if ($urandom_range(1) == 0) mant = 64'd0;
            end
            2: begin
                ex = 0;
                if ($urandom_range(2) == 0) mant = 64'd0;
            end
            // just below one or two in magnitude: ties near saturation, tiny results when negative
            3: begin
                ex   = bias - $urandom_range(1);
                mant = ~64'($urandom_range(1023));
            end
            4: ex = bias + $urandom_range(1, 5);
            default: ex = $urandom_range(bias - 45, bias + 1);
        endcase
        if (dbl)
            return {sgn, 11'(ex), mant[51:0]};
        return {$urandom, sgn, 8'(ex), mant[22:0]};
    endfunction

    function automatic logic [63:0] pick_sample(input logic [2:0] fmt);
        if (fmt == sfadler_pkg::FMT_FLT)
            return pick_float(1'b0);
        if (fmt == sfadler_pkg::FMT_DBL)
            return pick_float(1'b1);
        case ($urandom_range(7))
            0: return 64'd0;
            1: return 64'hFFFF_FFFF_FFFF_FFFF;
            2: return {$urandom, 32'h7FFF_FFFF};
            3: return {$urandom, 32'h8000_0000};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic test_integer_formats;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        set_format(sfadler_pkg::FMT_U8);
        push_sample(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0);
        push_sample(64'h0000_0000_0000_0000, 1'b0, 1'b1);
        push_sample(64'h0000_0000_0000_007F, 1'b1, 1'b1);
        set_format(sfadler_pkg::FMT_S16);
        push_sample(64'h0000_0000_0000_7FFF, 1'b1, 1'b0);
        push_sample(64'hFFFF_FFFF_FFFF_8000, 1'b0, 1'b1);
        set_format(sfadler_pkg::FMT_S32);
        push_sample(64'h0000_0000_7FFF_FFFF, 1'b1, 1'b0);
        push_sample(64'hFFFF_FFFF_8000_0000, 1'b0, 1'b0);
        push_sample(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1);
    endtask

    // signed zeros, infinities, NaN, saturation, subnormals
    task automatic test_float_formats;
        set_format(sfadler_pkg::FMT_FLT);
        push_sample(64'h0000_0000_0000_0000, 1'b1, 1'b0);
        push_sample(64'hFFFF_FFFF_8000_0000, 1'b0, 1'b0);
        push_sample(64'h0000_0000_7F80_0000, 1'b0, 1'b0);
        push_sample(64'h0000_0000_FF80_0000, 1'b0, 1'b0);
        push_sample(64'h0000_0000_7FC0_0001, 1'b0, 1'b0);
        push_sample(64'h0000_0000_3F80_0000, 1'b0, 1'b0);
        push_sample(64'h0000_0000_BF80_0000, 1'b0, 1'b0);
        push_sample(64'h0000_0000_0000_0001, 1'b0, 1'b1);
        set_format(sfadler_pkg::FMT_DBL);
        push_sample(64'h0000_0000_0000_0000, 1'b1, 1'b0);
        push_sample(64'h8000_0000_0000_0000, 1'b0, 1'b0);
        push_sample(64'h7FF0_0000_0000_0000, 1'b0, 1'b0);
        push_sample(64'h7FF8_0000_0000_0000, 1'b0, 1'b0);
        push_sample(64'hBFEF_FFFF_FFFF_FFFF, 1'b0, 1'b0);
        push_sample(64'h3FEF_FFFF_FFFF_FFFF, 1'b0, 1'b1);
    endtask

    // unmapped codes leave the sums alone, flags still act
    task automatic test_spare_formats;
        set_format(FMT_RSVD5);
        push_sample(64'h0000_0000_0000_0012, 1'b1, 1'b1);
        set_format(FMT_RSVD6);
        push_sample(64'h0000_0000_0000_00FF, 1'b0, 1'b1);
        set_format(FMT_RSVD7);
        push_sample(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1);
    endtask

    task automatic test_random_traffic(input int src_pct, input int sink_pct);
        logic [2:0] order[8];
        logic [2:0] tmp;
        int         i;
        int         j;
        int         n;
        int         sent;
        int         plen;
        bit         noisy;
        for (i = 0; i < 8; i++)
            order[i] = 3'(i);
        for (i = 7; i > 0; i--) begin
            j        = $urandom_range(i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        for (i = 0; i < 8; i++) begin
            set_format(order[i]);
            n    = (order[i] <= sfadler_pkg::FMT_DBL) ? 68 : 8;
            sent = 0;
            while (sent < n) begin
                plen  = ($urandom_range(9) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 8);
                noisy = ($urandom_range(9) == 0);
                for (j = 0; j < plen && sent < n; j++) begin
                    if (noisy)
                        push_sample(pick_sample(order[i]), 1'($urandom_range(1)),
                                    1'($urandom_range(1)));
                    else
                        push_sample(pick_sample(order[i]), j == 0, j == plen - 1);
                    sent++;
                end
            end
        end
    endtask

    // result side: compare each output beat, then choose next tready
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (checksum_q.size() == 0) begin
                $error("checksum: no result expected, got %h", m_tdata);
                err_count++;
            end else begin
                due_sum = checksum_q.pop_front();
                if (m_tdata !== due_sum) begin
                    $error("checksum: expected %h, got %h", due_sum, m_tdata);
                    err_count++;
                end
            end
        end
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        test_integer_formats();
        test_float_formats();
        test_spare_formats();
        test_random_traffic(0, 0);
        test_random_traffic(59, 0);
        test_random_traffic(0, 59);
        test_random_traffic(26, 26);
        s_tvalid <= 1'b0;
        while (checksum_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (err_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

>>> files.f
sv/sfadler_pkg.sv
sv/sfadler_map.sv
sv/sample_format_adler_checksum_top.sv
test/sample_format_adler_checksum_top_tb.sv
